@@ rtl/murmur3_pkg.sv @@
// ----------------------------------------------------------------------------
// murmur3_pkg
// Shared constants, command/status types for the MurmurHash3 x86_32 engine.
// ----------------------------------------------------------------------------
package murmur3_pkg;

    localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2   = 32'h1b873593;
    localparam logic [31:0] FOLD_ADD = 32'he6546b64;
    localparam logic [31:0] FMIX_C1  = 32'h85ebca6b;
    localparam logic [31:0] FMIX_C2  = 32'hc2b2ae35;
    localparam int unsigned ROT_BLOCK = 15;
    localparam int unsigned ROT_HASH  = 13;

    localparam logic [2:0] FULL_BYTES = 3'd4;

    typedef enum logic [2:0] {
        OP_NOP  = 3'd0,
        OP_LOAD = 3'd1,
        OP_MUL1 = 3'd2,
        OP_MUL2 = 3'd3,
        OP_FOLD = 3'd4,
        OP_FIN1 = 3'd5,
        OP_FIN2 = 3'd6,
        OP_FIN3 = 3'd7
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_status_t;

endpackage

@@ rtl/murmur3_dpath.sv @@
// ----------------------------------------------------------------------------
// murmur3_dpath
// Hash datapath: seed register, beat capture, one shared 32x32 multiplier,
// running hash, byte length and the result register.
// ----------------------------------------------------------------------------
module murmur3_dpath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [31:0]             cfg_wdata,
    input  logic [31:0]             data_word,
    input  logic [2:0]              byte_count,
    input  logic                    last,
    input  murmur3_pkg::dp_cmd_t    cmd,
    output murmur3_pkg::dp_status_t status,
    output logic [31:0]             hash
);

    logic [31:0] seed_reg;
    logic [31:0] word_reg, word_next;
    logic [31:0] k_reg;
    logic [31:0] h_reg, h_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] hash_reg;
    logic        last_reg;
    logic        full_reg, full_next;
    logic        none_reg, none_next;
    logic        at_start_reg;

    logic [2:0]  cnt_sat;
    logic [2:0]  cnt_eff;
    logic [31:0] mask;
    logic [31:0] h_base;
    logic [31:0] len_base;
    logic [31:0] mul_a, mul_b, mul_p;
    logic [31:0] k_rot;
    logic [31:0] fold_x, fold_r;
    logic [31:0] fin_t0, fin_t1, fin_t2;

    // Beat decode: count saturates at four, non-final beats always count four.
    always_comb
    begin
        cnt_sat  = (byte_count > murmur3_pkg::FULL_BYTES) ? murmur3_pkg::FULL_BYTES
                                                          : byte_count;
        cnt_eff  = last ? cnt_sat : murmur3_pkg::FULL_BYTES;
        case (cnt_eff)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase
        word_next = data_word & mask;
        full_next = (cnt_eff == murmur3_pkg::FULL_BYTES);
        none_next = (cnt_eff == 3'd0);
        h_base    = at_start_reg ? seed_reg : h_reg;
        len_base  = at_start_reg ? 32'd0 : len_reg;
        len_next  = len_base + {29'd0, cnt_eff};
    end

    assign k_rot  = {k_reg[31-murmur3_pkg::ROT_BLOCK:0],
                     k_reg[31:32-murmur3_pkg::ROT_BLOCK]};
    assign fold_x = h_reg ^ k_reg;
    assign fold_r = {fold_x[31-murmur3_pkg::ROT_HASH:0],
                     fold_x[31:32-murmur3_pkg::ROT_HASH]};
    assign fin_t0 = h_reg ^ len_reg;
    assign fin_t1 = fin_t0 ^ (fin_t0 >> 16);
    assign fin_t2 = h_reg ^ (h_reg >> 13);

    // Single shared multiplier, low 32 bits of the product.
    always_comb
    begin
        unique case (cmd.op)
            murmur3_pkg::OP_MUL1:
            begin
                mul_a = word_reg;
                mul_b = murmur3_pkg::MIX_C1;
            end
            murmur3_pkg::OP_MUL2:
            begin
                mul_a = k_rot;
                mul_b = murmur3_pkg::MIX_C2;
            end
            murmur3_pkg::OP_FIN1:
            begin
                mul_a = fin_t1;
                mul_b = murmur3_pkg::FMIX_C1;
            end
            default:
            begin
                mul_a = fin_t2;
                mul_b = murmur3_pkg::FMIX_C2;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        h_next = h_reg;
        unique case (cmd.op)
            murmur3_pkg::OP_LOAD: h_next = h_base;
            murmur3_pkg::OP_FOLD:
            begin
                if (full_reg)
                    h_next = (fold_r << 2) + fold_r + murmur3_pkg::FOLD_ADD;
                else if (!none_reg)
                    h_next = fold_x;
            end
            murmur3_pkg::OP_FIN1: h_next = mul_p;
            murmur3_pkg::OP_FIN2: h_next = mul_p;
            default:              h_next = h_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg     <= 32'd0;
            at_start_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
                seed_reg <= cfg_wdata;
            if (cmd.op == murmur3_pkg::OP_LOAD)
                at_start_reg <= last;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        if (cmd.op == murmur3_pkg::OP_LOAD)
        begin
            word_reg <= word_next;
            len_reg  <= len_next;
            last_reg <= last;
            full_reg <= full_next;
            none_reg <= none_next;
        end
        if (cmd.op == murmur3_pkg::OP_MUL1 || cmd.op == murmur3_pkg::OP_MUL2)
            k_reg <= mul_p;
        if (cmd.op == murmur3_pkg::OP_FIN3)
            hash_reg <= h_reg ^ (h_reg >> 16);
    end

    assign status.last = last_reg;
    assign hash        = hash_reg;

endmodule

@@ rtl/murmur3_ctrl.sv @@
// ----------------------------------------------------------------------------
// murmur3_ctrl
// Sequencer for the hash datapath: steps each beat through the block mix,
// the fold and, on the final beat, the finalizer; owns the output valid.
// ----------------------------------------------------------------------------
module murmur3_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  murmur3_pkg::dp_status_t status,
    output murmur3_pkg::dp_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL1 = 7'b0000010,
        S_MUL2 = 7'b0000100,
        S_FOLD = 7'b0001000,
        S_FIN1 = 7'b0010000,
        S_FIN2 = 7'b0100000,
        S_FIN3 = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // Result slot frees up in the same cycle it is taken.
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = murmur3_pkg::OP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = murmur3_pkg::OP_LOAD;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.op     = murmur3_pkg::OP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.op     = murmur3_pkg::OP_MUL2;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.op     = murmur3_pkg::OP_FOLD;
                state_next = status.last ? S_FIN1 : S_IDLE;
            end
            S_FIN1:
            begin
                cmd.op     = murmur3_pkg::OP_FIN1;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                cmd.op     = murmur3_pkg::OP_FIN2;
                state_next = S_FIN3;
            end
            S_FIN3:
            begin
                if (slot_free)
                begin
                    cmd.op         = murmur3_pkg::OP_FIN3;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a beat but sequencer stayed idle");

    a_body_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FOLD && !status.last) |=> (state_reg == S_IDLE && !$rose(out_valid)))
        else $error("body beat did not return to idle cleanly");

    a_fin_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN3 && !out_valid_reg) |=> (out_valid && state_reg == S_IDLE))
        else $error("finalizer did not present result into free slot");

    a_stall_holds_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN3 && out_valid_reg && !out_ready) |=> state_reg == S_FIN3)
        else $error("result overwritten while receiver stalled");

endmodule

@@ rtl/murmur3_32_hash_engine.sv @@
// ----------------------------------------------------------------------------
// murmur3_32_hash_engine
// MurmurHash3 x86_32 over a stream of little-endian 32-bit message words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat per message word, data_word
//   with its first byte in bits 7:0. Beats with last=0 are full blocks;
//   the beat with last=1 carries byte_count bytes (0..4, 5..7 act as 4).
//   Output channel (out_valid/out_ready): one hash beat per message.
//   Config: cfg_we/cfg_wdata writes the seed, sampled at a message's
//   first beat; write it only while the engine is idle.
//   Sequencing: each beat steps through load, multiply by c1, multiply by
//   c2 on the shared multiplier, then the fold step, and in_ready stays
//   low until the sequencer is idle again. A final beat adds two more
//   multiplier passes for fmix32 plus the result load.
//   Hash and out_valid are registered together in the last finalizer step.
//   A finished hash sits in its own output register, so the next message
//   can start while it waits; if a second hash is ready before the first
//   is taken, the engine holds in the last finalizer step.
//   Reset: seed clears to zero, the engine idles and out_valid drops.
// ----------------------------------------------------------------------------
module murmur3_32_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash
);

    murmur3_pkg::dp_cmd_t    cmd;
    murmur3_pkg::dp_status_t status;

    murmur3_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    murmur3_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last       (last),
        .cmd        (cmd),
        .status     (status),
        .hash       (hash)
    );

endmodule

@@ test/murmur3_32_hash_engine_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// murmur3_32_hash_engine_tb
// Self-checking bench: streams messages into the engine, predicts each hash
// with a local MurmurHash3 x86_32 calculation and checks every output beat
// in order, under random input gaps, output stalls and seed changes.
// ----------------------------------------------------------------------------
module murmur3_32_hash_engine_tb;

    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_BEATS  = 1850;
    localparam int SEGMENT_BEATS = 250;
    localparam int MAX_SHOWN     = 10;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [31:0] cfg_wdata  = '0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [31:0] data_word  = '0;
    logic [2:0]  byte_count = '0;
    logic        last       = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [31:0] hash;

    // local copy of the engine state
    logic [31:0] seed_now   = '0;
    logic [31:0] chain_hash = '0;
    logic [31:0] chain_len  = '0;
    logic        chain_open = 1'b0;
    logic [31:0] hash_due_q[$];

    int       beats_sent    = 0;
    int       hashes_seen   = 0;
    int       fail_count    = 0;
    int       shown_count   = 0;
    int       seeds_written = 0;
    int       tx_burst_left = 0;
    bit       tx_gaps_on    = 1'b0;
    rx_mode_t rx_mode       = RX_ALWAYS;
    int       rx_hold_req   = 0;

    murmur3_32_hash_engine u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash       (hash)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble_block(input logic [31:0] k);
        logic [31:0] t;
        t = k * murmur3_pkg::MIX_C1;
        t = rotl(t, murmur3_pkg::ROT_BLOCK);
        t = t * murmur3_pkg::MIX_C2;
        return t;
    endfunction

    function automatic logic [31:0] absorb_block(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] t;
        t = rotl(h ^ scramble_block(k), murmur3_pkg::ROT_HASH);
        t = t * 32'd5 + murmur3_pkg::FOLD_ADD;
        return t;
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * murmur3_pkg::FMIX_C1;
        t = t ^ (t >> 13);
        t = t * murmur3_pkg::FMIX_C2;
        t = t ^ (t >> 16);
        return t;
    endfunction

    function automatic void absorb_beat(input logic [31:0] w, input logic [2:0] cnt,
                                        input logic lst);
        logic [31:0] h;
        logic [31:0] len;
        logic [31:0] kept;
        logic [2:0]  n;
        h   = chain_open ? chain_hash : seed_now;
        len = chain_open ? chain_len : 32'd0;
        if (!lst)
        begin
            chain_hash = absorb_block(h, w);
            chain_len  = len + 32'd4;
            chain_open = 1'b1;
        end
        else
        begin
            n = (cnt > murmur3_pkg::FULL_BYTES) ? murmur3_pkg::FULL_BYTES : cnt;
            if (n == murmur3_pkg::FULL_BYTES)
                h = absorb_block(h, w);
            else if (n != 3'd0)
            begin
                // tail bytes: only the valid low bytes take part
                kept = w & ((32'd1 << (8 * n)) - 32'd1);
                h = h ^ scramble_block(kept);
            end
            h = h ^ (len + 32'(n));
            hash_due_q.push_back(avalanche(h));
            chain_hash = '0;
            chain_len  = '0;
            chain_open = 1'b0;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            absorb_beat(data_word, byte_count, last);
    end

    always @(posedge clk)
    begin : check_hash
        logic [31:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            hashes_seen++;
            if (hash_due_q.size() == 0)
            begin
                fail_count++;
                shown_count++;
                if (shown_count <= MAX_SHOWN)
                    $display("hash beat %0d: got %08h with no message pending",
                             hashes_seen, hash);
            end
            else
            begin
                want = hash_due_q.pop_front();
                if (hash !== want)
                begin
                    fail_count++;
                    shown_count++;
                    if (shown_count <= MAX_SHOWN)
                        $display("hash beat %0d: expected %08h, got %08h",
                                 hashes_seen, want, hash);
                end
            end
        end
    end

    // output side: long hold-offs are requested by the tests, counted here
    initial
    begin : receiver
        int phase;
        phase = 0;
        forever
        begin
            @(posedge clk);
            phase++;
            if (rx_hold_req > 0)
            begin
                out_ready <= 1'b0;
                rx_hold_req--;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS: out_ready <= 1'b1;
                    RX_RANDOM: out_ready <= ($urandom_range(0, 9) < 6);
                    default:   out_ready <= ((phase % 7) < 3);
                endcase
            end
        end
    end

    task automatic send_beat(input logic [31:0] w, input logic [2:0] cnt, input logic lst);
        int gap;
        if (tx_burst_left == 0)
        begin
            tx_burst_left = $urandom_range(1, 24);
            gap = tx_gaps_on ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        tx_burst_left--;
        in_valid   <= 1'b1;
        data_word  <= w;
        byte_count <= cnt;
        last       <= lst;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
    endtask

    // body beats carry junk in byte_count, which the engine must ignore
    task automatic send_message(input int body_words, input logic [2:0] tail_cnt);
        int i;
        for (i = 0; i < body_words; i++)
            send_beat($urandom, 3'($urandom_range(0, 7)), 1'b0);
        send_beat($urandom, tail_cnt, 1'b1);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (hash_due_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        seed_now  = v;
        seeds_written++;
    endtask

    function automatic logic [2:0] pick_tail_count();
        if ($urandom_range(0, 9) < 8)
            return 3'($urandom_range(0, 4));
        return 3'($urandom_range(5, 7));
    endfunction

    task automatic test_directed_vectors();
        int c;
        tx_gaps_on = 1'b0;
        rx_mode    = RX_ALWAYS;
        // empty and short messages, with and without junk above the count
        send_beat(32'h0000_0000, 3'd0, 1'b1);
        send_beat(32'hffff_ffff, 3'd0, 1'b1);
        for (c = 1; c <= 4; c++)
            send_beat(32'hffff_ffff, 3'(c), 1'b1);
        send_beat(32'h0000_0000, 3'd4, 1'b1);
        // counts above four act as a full block, and body beats ignore their count
        for (c = 5; c <= 7; c++)
            send_beat(32'h1234_5678, 3'(c), 1'b1);
        send_beat(32'h0000_0000, 3'd0, 1'b0);
        send_beat(32'hffff_ffff, 3'd7, 1'b0);
        send_beat(32'h00ff_00ff, 3'd3, 1'b1);
        // body then an empty final beat
        send_beat(32'h8000_0001, 3'd4, 1'b0);
        send_beat(32'hffff_ffff, 3'd0, 1'b1);
        wait_idle();
    endtask

    task automatic test_seed_extremes();
        logic [31:0] seeds[5];
        int i;
        seeds[0] = 32'hffff_ffff;
        seeds[1] = 32'h8000_0000;
        seeds[2] = 32'h0000_0001;
        seeds[3] = $urandom;
        seeds[4] = 32'h0000_0000;
        tx_gaps_on = 1'b1;
        rx_mode    = RX_RANDOM;
        for (i = 0; i < 5; i++)
        begin
            write_seed(seeds[i]);
            send_message(0, 3'd4);
            send_message(2, 3'd3);
            send_message(1, 3'd0);
            wait_idle();
        end
    endtask

    // the message in flight keeps the seed it opened with
    task automatic test_seed_mid_message();
        rx_mode = RX_PATTERN;
        write_seed(32'h5a5a_0f0f);
        send_beat($urandom, 3'd4, 1'b0);
        send_beat($urandom, 3'd0, 1'b0);
        wait_idle();
        write_seed(32'hc3c3_7777);
        send_beat($urandom, 3'd2, 1'b1);
        send_message(1, 3'd4);
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        int i;
        tx_gaps_on = 1'b0;
        rx_mode    = RX_ALWAYS;
        @(posedge clk);
        rx_hold_req = 400;
        for (i = 0; i < 30; i++)
            send_message($urandom_range(0, 1), pick_tail_count());
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int start;
        int seg_end;
        int r;
        int body;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS)
        begin
            wait_idle();
            r = $urandom_range(0, 3);
            if (r == 0)
                write_seed(32'h0000_0000);
            else if (r == 1)
                write_seed(32'hffff_ffff);
            else
                write_seed($urandom);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_mode    = rx_mode_t'($urandom_range(0, 2));
            seg_end    = beats_sent + SEGMENT_BEATS;
            while (beats_sent < seg_end && beats_sent - start < RANDOM_BEATS)
            begin
                r = $urandom_range(0, 19);
                if (r < 10)
                    body = $urandom_range(0, 3);
                else if (r < 17)
                    body = $urandom_range(4, 12);
                else
                    body = $urandom_range(13, 60);
                send_message(body, pick_tail_count());
            end
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_vectors();
        test_seed_extremes();
        test_seed_mid_message();
        test_output_backpressure();
        test_random_traffic();
        if (hash_due_q.size() != 0)
        begin
            fail_count++;
            $display("%0d hashes never arrived", hash_due_q.size());
        end
        $display("Sent %0d beats, checked %0d hashes across %0d seed settings.",
                 beats_sent, hashes_seen, seeds_written + 1);
        $display("Failures: %0d", fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // generous bound: the full run needs well under a tenth of this
    initial
    begin
        #5_000_000;
        $display("Timeout waiting on the engine");
        $display("Regression FAIL");
        $finish;
    end

endmodule
